@@ rtl/huffman_bit_packing_encoder_assert.svh @@
// Assertion macros shared by the Huffman bit packer RTL.
`ifndef HUFFMAN_BIT_PACKING_ENCODER_ASSERT_SVH
`define HUFFMAN_BIT_PACKING_ENCODER_ASSERT_SVH

// Clocked check, switched off while reset is asserted.
`ifndef SYNTH
`define HBPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define HBPE_ASSERT(lbl, prop, msg)
`endif

// Clocked check that also holds through reset.
`ifndef SYNTH
`define HBPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBPE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/hbpe_pkg.sv @@
// Shared types and constants of the Huffman bit packer.
`default_nettype none

package hbpe_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int NUM_SYMBOLS_DEF  = 256;

    localparam int SYM_W     = 8;
    localparam int IN_LEN_W  = 6;
    localparam int CODE_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int FILL_W    = 3;
    localparam int MAX_BYTES = 4;
    localparam int CNT_W     = 3;
    localparam int ACC_W     = CODE_W + BYTE_W;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 8;

    // Input item kinds, carried on tuser
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } mode_t;

    // Bytes produced by one item, first byte in the top bits
    typedef struct packed {
        logic [CNT_W-1:0]            count;
        logic                        status;
        logic [MAX_BYTES*BYTE_W-1:0] bytes;
    } pk_result_t;

endpackage

`default_nettype wire

@@ rtl/hbpe_table.sv @@
// Code table memory: length and code bits per symbol, with per-entry valid bits.
`default_nettype none
`include "huffman_bit_packing_encoder_assert.svh"

module hbpe_table #(
    parameter int NUM_SYMBOLS = hbpe_pkg::NUM_SYMBOLS_DEF,
    parameter int LEN_W       = 6,
    parameter int AW          = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [LEN_W-1:0]          wlen,
    input  wire logic [hbpe_pkg::CODE_W-1:0] wbits,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic                           rd_vld,
    output logic [LEN_W-1:0]               rd_len,
    output logic [hbpe_pkg::CODE_W-1:0]    rd_bits
);
    import hbpe_pkg::*;

    logic [LEN_W+CODE_W-1:0] code_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0]  valid_reg;
    logic [LEN_W+CODE_W-1:0] rd_data_reg;
    logic                    rd_vld_reg;

    // Write entry on load
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            code_mem[waddr] <= {wlen, wbits};
        end
    end

    // Read entry, hold data while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= code_mem[raddr];
            rd_vld_reg  <= valid_reg[raddr];
        end
    end

    // Mark written entries; reset makes every symbol absent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign rd_vld  = rd_vld_reg;
    assign rd_len  = rd_data_reg[LEN_W+CODE_W-1:CODE_W];
    assign rd_bits = rd_data_reg[CODE_W-1:0];

    `HBPE_ASSERT_ALWAYS(a_no_rw_collide, !(we && re), "table read and write in one cycle")

endmodule

`default_nettype wire

@@ rtl/hbpe_packer.sv @@
// Bit packer: merges a code into the pending byte and splits off full bytes.
`default_nettype none
`include "huffman_bit_packing_encoder_assert.svh"

module hbpe_packer #(
    parameter int LEN_W = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire hbpe_pkg::mode_t             mode,
    input  wire logic                        in_range,
    input  wire logic                        rd_vld,
    input  wire logic [LEN_W-1:0]            rd_len,
    input  wire logic [hbpe_pkg::CODE_W-1:0] rd_bits,
    input  wire logic                        adv,
    output hbpe_pkg::pk_result_t             res
);
    import hbpe_pkg::*;

    localparam logic [IN_LEN_W-1:0] CODE_W_L = IN_LEN_W'(CODE_W);

    logic [BYTE_W-1:0]   pending_reg;
    logic [BYTE_W-1:0]   pending_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [IN_LEN_W-1:0] eff_len;
    logic [IN_LEN_W-1:0] shamt;
    logic [CODE_W-1:0]   code_al;
    logic [ACC_W-1:0]    acc;
    logic [IN_LEN_W-1:0] total;
    logic [CNT_W-1:0]    nbytes;
    logic [BYTE_W-1:0]   tail_byte;

    // Left-align the code and place it after the bits already pending
    always_comb
    begin
        eff_len = (in_range && rd_vld) ? IN_LEN_W'(rd_len) : '0;
        shamt   = CODE_W_L - eff_len;
        code_al = rd_bits << shamt;
        acc     = ({code_al, {BYTE_W{1'b0}}} >> fill_reg)
                | {pending_reg, {CODE_W{1'b0}}};
        total   = IN_LEN_W'(fill_reg) + eff_len;
        nbytes  = total[IN_LEN_W-1:FILL_W];
    end

    // Pick the partial byte left after the full ones
    always_comb
    begin
        case (nbytes)
            3'd0:    tail_byte = acc[39:32];
            3'd1:    tail_byte = acc[31:24];
            3'd2:    tail_byte = acc[23:16];
            3'd3:    tail_byte = acc[15:8];
            3'd4:    tail_byte = acc[7:0];
            default: tail_byte = acc[39:32];
        endcase
    end

    // Form results and next packer state per item kind
    always_comb
    begin
        res          = '0;
        pending_next = pending_reg;
        fill_next    = fill_reg;
        case (mode)
            MODE_ENCODE:
            begin
                if (eff_len == '0)
                begin
                    res.count  = 3'd1;
                    res.status = 1'b1;
                end
                else
                begin
                    res.count    = nbytes;
                    res.bytes    = acc[ACC_W-1:BYTE_W];
                    pending_next = tail_byte;
                    fill_next    = total[FILL_W-1:0];
                end
            end
            MODE_FLUSH:
            begin
                res.count    = (fill_reg != '0) ? 3'd1 : 3'd0;
                res.bytes    = {pending_reg, {(CODE_W-BYTE_W){1'b0}}};
                pending_next = '0;
                fill_next    = '0;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // Advance packer state when the item leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            fill_reg    <= '0;
        end
        else if (adv)
        begin
            pending_reg <= pending_next;
            fill_reg    <= fill_next;
        end
    end

    `HBPE_ASSERT(a_err_single, res.status |-> (res.count == 3'd1), "error item must give one word")
    `HBPE_ASSERT(a_flush_clear, (adv && mode == MODE_FLUSH) |=> (fill_reg == 3'd0 && pending_reg == 8'd0), "flush left bits pending")
    `HBPE_ASSERT(a_pad_zero, (8'(pending_reg << fill_reg) == 8'd0), "pending byte has stray bits below fill")

endmodule

`default_nettype wire

@@ rtl/hbpe_outq.sv @@
// Output queue: holds up to four bytes of one item and sends them one per word.
`default_nettype none
`include "huffman_bit_packing_encoder_assert.svh"

module hbpe_outq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire hbpe_pkg::pk_result_t res,
    output logic                      free,
    output logic                      tvalid,
    input  wire logic                 tready,
    output logic [hbpe_pkg::BYTE_W-1:0] tdata,
    output logic                      tuser,
    output logic                      tlast
);
    import hbpe_pkg::*;

    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic [MAX_BYTES*BYTE_W-1:0] bytes_reg;
    logic [MAX_BYTES*BYTE_W-1:0] bytes_next;
    logic                        status_reg;
    logic                        status_next;
    logic                        pop;

    assign pop  = tvalid && tready;
    assign free = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && tready);

    // Load a new item or shift out the sent byte
    always_comb
    begin
        cnt_next    = cnt_reg;
        bytes_next  = bytes_reg;
        status_next = status_reg;
        if (load)
        begin
            cnt_next    = res.count;
            bytes_next  = res.bytes;
            status_next = res.status;
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 3'd1;
            bytes_next = bytes_reg << BYTE_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg  <= bytes_next;
        status_reg <= status_next;
    end

    assign tvalid = (cnt_reg != 3'd0);
    assign tdata  = bytes_reg[MAX_BYTES*BYTE_W-1 -: BYTE_W];
    assign tuser  = status_reg;
    assign tlast  = (cnt_reg == 3'd1);

    `HBPE_ASSERT(a_no_overrun, load |-> free, "queue loaded over unsent bytes")
    `HBPE_ASSERT(a_cnt_max, (cnt_reg <= 3'd4), "queue count out of range")

endmodule

`default_nettype wire

@@ rtl/huffman_bit_packing_encoder.sv @@
// An item is registered in stage one with its table read, and its bytes are then
// loaded into the output queue when the item leaves stage one.
// Throughput: one item per cycle while each item yields at most one byte and the output
// is ready; an item that completes k bytes holds the output queue until all have left, one per ready cycle.
// The code table is a read/write memory, read in the accept cycle and never written then.
// Reset: packer cleared and every symbol made absent at once by per-entry valid bits.
`default_nettype none

module huffman_bit_packing_encoder #(
    parameter int MAX_CODE_LEN = hbpe_pkg::MAX_CODE_LEN_DEF,
    parameter int NUM_SYMBOLS  = hbpe_pkg::NUM_SYMBOLS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // symbol [7:0], code_length [13:8], code_bits [45:14], zero fill [47:46]
    input  wire logic [hbpe_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // mode [1:0]
    input  wire logic [1:0]                     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_byte [7:0]
    output logic [hbpe_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status [0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import hbpe_pkg::*;

    localparam int CAP_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int LEN_W   = $clog2(CAP_LEN + 1);
    localparam int AW      = $clog2(NUM_SYMBOLS);

    logic [SYM_W-1:0]    in_sym;
    logic [IN_LEN_W-1:0] in_len;
    logic [CODE_W-1:0]   in_bits;
    mode_t               in_mode;
    logic                in_range;
    logic                accept;
    logic [LEN_W-1:0]    wlen;
    logic                we;
    logic                re;

    logic                s1_valid_reg;
    mode_t               s1_mode_reg;
    logic                s1_range_reg;
    logic                adv;
    logic                q_free;

    logic                rd_vld;
    logic [LEN_W-1:0]    rd_len;
    logic [CODE_W-1:0]   rd_bits;
    pk_result_t          res;

    // Unpack input word
    assign in_sym   = s_axis_tdata[7:0];
    assign in_len   = s_axis_tdata[13:8];
    assign in_bits  = s_axis_tdata[45:14];
    assign in_mode  = mode_t'(s_axis_tuser);
    assign in_range = ({1'b0, in_sym} < (SYM_W+1)'(NUM_SYMBOLS));

    // Accept a word whenever stage one is empty or leaving
    assign adv           = s1_valid_reg && ((res.count == 3'd0) || q_free);
    assign s_axis_tready = !s1_valid_reg || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Saturate loaded length to the cap
    assign wlen = (in_len > IN_LEN_W'(CAP_LEN)) ? LEN_W'(CAP_LEN) : LEN_W'(in_len);
    assign we   = accept && (in_mode == MODE_LOAD) && in_range;
    assign re   = accept && (in_mode == MODE_ENCODE);

    // Stage one item register, aligned with the table read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_mode_reg  <= MODE_LOAD;
            s1_range_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_mode_reg  <= in_mode;
                s1_range_reg <= in_range;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    hbpe_table #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .LEN_W       (LEN_W),
        .AW          (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (we),
        .waddr   (in_sym[AW-1:0]),
        .wlen    (wlen),
        .wbits   (in_bits),
        .re      (re),
        .raddr   (in_sym[AW-1:0]),
        .rd_vld  (rd_vld),
        .rd_len  (rd_len),
        .rd_bits (rd_bits)
    );

    hbpe_packer #(
        .LEN_W (LEN_W)
    ) u_packer (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (s1_mode_reg),
        .in_range (s1_range_reg),
        .rd_vld   (rd_vld),
        .rd_len   (rd_len),
        .rd_bits  (rd_bits),
        .adv      (adv),
        .res      (res)
    );

    hbpe_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (adv && (res.count != 3'd0)),
        .res    (res),
        .free   (q_free),
        .tvalid (m_axis_tvalid),
        .tready (m_axis_tready),
        .tdata  (m_axis_tdata),
        .tuser  (m_axis_tuser),
        .tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ tb/packed_byte_checker.sv @@
// Checker for the Huffman bit packer: predicts the packed byte stream and compares it.
`default_nettype none

module packed_byte_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    // symbol [7:0], code_length [13:8], code_bits [45:14], zero fill [47:46]
    input  wire logic [hbpe_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // mode [1:0]
    input  wire logic [1:0]                     s_axis_tuser,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_byte [7:0]
    input  wire logic [hbpe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status [0]
    input  wire logic                           m_axis_tuser,
    input  wire logic                           m_axis_tlast,
    output int                                  error_count,
    output int                                  pending_results
);
    import hbpe_pkg::*;

    // Longest code the table keeps: limited by the parameter and by the code field
    localparam int CODE_LEN_CAP = (MAX_CODE_LEN_DEF < CODE_W) ? MAX_CODE_LEN_DEF : CODE_W;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              status;
        logic              last;
    } packed_byte_t;

    logic [IN_LEN_W-1:0] len_table [0:NUM_SYMBOLS_DEF-1];
    logic [CODE_W-1:0]   code_table [0:NUM_SYMBOLS_DEF-1];
    logic [BYTE_W-1:0]   pending_bits;
    logic [FILL_W-1:0]   fill_count;
    packed_byte_t        expected_bytes [$];

    function automatic packed_byte_t make_byte(input logic [BYTE_W-1:0] value,
                                               input logic status);
        packed_byte_t word;
        word.out_byte = value;
        word.status   = status;
        word.last     = 1'b0;
        return word;
    endfunction

    // Update the table and packer for one accepted word and queue the bytes it yields
    task automatic predict_packing(input logic [1:0]          kind,
                                   input logic [SYM_W-1:0]    sym,
                                   input logic [IN_LEN_W-1:0] len_in,
                                   input logic [CODE_W-1:0]   code_in);
        packed_byte_t        batch [0:MAX_BYTES];
        int                  n_new;
        int                  i;
        logic [IN_LEN_W-1:0] len;
        n_new = 0;
        case (kind)
            MODE_LOAD:
            begin
                len_table[sym]  = (len_in > CODE_LEN_CAP) ? IN_LEN_W'(CODE_LEN_CAP) : len_in;
                code_table[sym] = code_in;
            end
            MODE_ENCODE:
            begin
                len = len_table[sym];
                if (len == '0)
                begin
                    // absent symbol: one error word, packer untouched
                    batch[0] = make_byte('0, 1'b1);
                    n_new    = 1;
                end
                else
                begin
                    // append code bits, most significant first, from bit 7 down
                    for (i = int'(len) - 1; i >= 0; i--)
                    begin
                        pending_bits[BYTE_W - 1 - int'(fill_count)] = code_table[sym][i];
                        if (fill_count == FILL_W'(BYTE_W - 1))
                        begin
                            batch[n_new] = make_byte(pending_bits, 1'b0);
                            n_new++;
                            pending_bits = '0;
                            fill_count   = '0;
                        end
                        else
                        begin
                            fill_count++;
                        end
                    end
                end
            end
            MODE_FLUSH:
            begin
                if (fill_count != '0)
                begin
                    batch[0] = make_byte(pending_bits, 1'b0);
                    n_new    = 1;
                end
                pending_bits = '0;
                fill_count   = '0;
            end
            default: ;
        endcase
        if (n_new > 0)
        begin
            batch[n_new - 1].last = 1'b1;
        end
        for (i = 0; i < n_new; i++)
        begin
            expected_bytes.push_back(batch[i]);
        end
    endtask

    // Predict on input words, compare output words against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        packed_byte_t want;
        int           k;
        if (!rst_n)
        begin
            for (k = 0; k < NUM_SYMBOLS_DEF; k++)
            begin
                len_table[k] = '0;
            end
            pending_bits = '0;
            fill_count   = '0;
            expected_bytes.delete();
            error_count     = 0;
            pending_results = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_packing(s_axis_tuser, s_axis_tdata[SYM_W-1:0],
                                s_axis_tdata[SYM_W +: IN_LEN_W],
                                s_axis_tdata[SYM_W + IN_LEN_W +: CODE_W]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, got byte %h status %b last %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.out_byte)
                    begin
                        $display("%0t: out_byte mismatch: expected %h, got %h",
                                 $time, want.out_byte, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %b, got %b",
                                 $time, want.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %b, got %b",
                                 $time, want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            pending_results = expected_bytes.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Top of the Huffman bit packer testbench: clock, reset, stimulus, watchdog and verdict.
`default_nettype none

module tb_top;
    import hbpe_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CODE_LEN_CAP = (MAX_CODE_LEN_DEF < CODE_W) ? MAX_CODE_LEN_DEF : CODE_W;
    localparam int MAX_GAP       = 17;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 330;
    localparam int FILL_BITS     = IN_DATA_W - SYM_W - IN_LEN_W - CODE_W;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    int error_count;
    int pending_results;
    int sym_len [0:NUM_SYMBOLS_DEF-1];
    int sender_calm;
    int receiver_calm;
    bit sender_rush;
    bit hold_req;
    int items_sent;
    int idle_cycles;

    huffman_bit_packing_encoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    packed_byte_checker byte_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .error_count    (error_count),
        .pending_results(pending_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle cycles before the next word; runs of zero now and then
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 14) == 0)
        begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Mostly short codes, some long, some overlong, some absent
    function automatic logic [IN_LEN_W-1:0] draw_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return IN_LEN_W'($urandom_range(1, 12));
        else if (r < 85)
            return IN_LEN_W'($urandom_range(13, 32));
        else if (r < 93)
            return IN_LEN_W'($urandom_range(33, 63));
        return '0;
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol(input bit want_present);
        logic [SYM_W-1:0] sym;
        int               tries;
        sym = SYM_W'($urandom_range(0, NUM_SYMBOLS_DEF - 1));
        for (tries = 0; want_present && sym_len[sym] == 0 && tries < 64; tries++)
        begin
            sym = SYM_W'($urandom_range(0, NUM_SYMBOLS_DEF - 1));
        end
        return sym;
    endfunction

    // Present one word on the input, hold it until taken; returns at a falling edge
    task automatic offer_word(input logic [1:0]          kind,
                              input logic [SYM_W-1:0]    sym,
                              input logic [IN_LEN_W-1:0] len,
                              input logic [CODE_W-1:0]   bits);
        int gap;
        gap = draw_gap(sender_calm);
        if (gap > 0 && !sender_rush)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{FILL_BITS{1'b0}}, bits, len, sym};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        if (kind != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic load_entry(input logic [SYM_W-1:0]    sym,
                              input logic [IN_LEN_W-1:0] len,
                              input logic [CODE_W-1:0]   bits);
        offer_word(MODE_LOAD, sym, len, bits);
        sym_len[sym] = (len > CODE_LEN_CAP) ? CODE_LEN_CAP : int'(len);
    endtask

    task automatic encode_symbol(input logic [SYM_W-1:0] sym);
        offer_word(MODE_ENCODE, sym, IN_LEN_W'($urandom_range(0, 63)), CODE_W'($urandom()));
    endtask

    task automatic flush_packer();
        offer_word(MODE_FLUSH, SYM_W'($urandom_range(0, 255)), IN_LEN_W'($urandom_range(0, 63)),
                   CODE_W'($urandom()));
    endtask

    // Drop valid and wait until every predicted byte has left the block
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0) @(negedge clk);
    endtask

    // Output side: random stalls per word, one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = draw_gap(receiver_calm);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Abort when neither side moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and verdict
    initial
    begin
        bit hold_done;
        bit pause_done;
        int k;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // absent symbol straight after reset, then a flush with nothing held
        encode_symbol(8'd0);
        flush_packer();
        load_entry(8'd0,   6'd1,  32'h0000_0001);
        load_entry(8'd255, 6'd32, 32'hFFFF_FFFF);
        load_entry(8'd1,   6'd63, 32'hA5A5_A5A5);
        load_entry(8'd2,   6'd0,  32'hFFFF_FFFF);
        load_entry(8'd3,   6'd8,  32'h0000_005A);
        load_entry(8'd4,   6'd33, 32'h0000_0000);
        load_entry(8'd5,   6'd7,  32'hFFFF_FF7F);
        // full-width and capped codes, four bytes each
        encode_symbol(8'd255);
        encode_symbol(8'd1);
        // one bit held, then a byte completes across the boundary
        encode_symbol(8'd0);
        encode_symbol(8'd3);
        // absent symbol must leave the held bit alone
        encode_symbol(8'd2);
        flush_packer();
        flush_packer();
        offer_word(MODE_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
        encode_symbol(8'd4);
        encode_symbol(8'd5);
        encode_symbol(8'd0);
        encode_symbol(8'd5);
        flush_packer();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            // block the output for a long stretch while words keep coming
            if (!hold_done && items_sent >= 100)
            begin
                hold_done   = 1'b1;
                hold_req    = 1'b1;
                sender_rush = 1'b1;
                for (k = 0; k < 30; k++)
                    encode_symbol(pick_symbol(1'b1));
                sender_rush = 1'b0;
            end
            if (!pause_done && items_sent >= 200)
            begin
                pause_done = 1'b1;
                wait_drained();
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    load_entry(pick_symbol(1'b0), draw_length(), CODE_W'($urandom()));
            end
            repeat ($urandom_range(1, 12))
                encode_symbol(pick_symbol($urandom_range(0, 6) != 0));
            if ($urandom_range(0, 1) == 0)
                flush_packer();
            if ($urandom_range(0, 9) == 0)
                offer_word(MODE_UNUSED, SYM_W'($urandom_range(0, 255)),
                           IN_LEN_W'($urandom_range(0, 63)), CODE_W'($urandom()));
            if ($urandom_range(0, 11) == 0)
                wait_drained();
        end
        flush_packer();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
